// File: design/mqttpd_pkg.sv
`default_nettype none

package mqttpd_pkg;

    localparam int unsigned TOPIC_MAX_DEF   = 64;
    localparam int unsigned PAYLOAD_MAX_DEF = 256;
    localparam int unsigned MAX_FRAME_DEF   = 65535;

    localparam int unsigned PL_W = 9;
    localparam int unsigned TL_W = 6;

    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    localparam logic [3:0] T_CONNACK  = 4'd2;
    localparam logic [3:0] T_PUBLISH  = 4'd3;
    localparam logic [3:0] T_PUBACK   = 4'd4;
    localparam logic [3:0] T_SUBACK   = 4'd9;
    localparam logic [3:0] T_PINGRESP = 4'd13;

    localparam logic [3:0] ROLE_TYPE      = 4'd0;
    localparam logic [3:0] ROLE_LEN       = 4'd1;
    localparam logic [3:0] ROLE_VAR       = 4'd2;
    localparam logic [3:0] ROLE_TOPIC_LEN = 4'd3;
    localparam logic [3:0] ROLE_TOPIC_KEP = 4'd4;
    localparam logic [3:0] ROLE_TOPIC_DRP = 4'd5;
    localparam logic [3:0] ROLE_PKT_ID    = 4'd6;
    localparam logic [3:0] ROLE_PAY_KEP   = 4'd7;
    localparam logic [3:0] ROLE_PAY_DRP   = 4'd8;
    localparam logic [3:0] ROLE_IGNORED   = 4'd9;

    localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
    localparam logic [2:0] KIND_CONNACK  = 3'd1;
    localparam logic [2:0] KIND_PUBLISH  = 3'd2;
    localparam logic [2:0] KIND_SUBACK   = 3'd3;
    localparam logic [2:0] KIND_PINGRESP = 3'd4;
    localparam logic [2:0] KIND_PUBACK   = 3'd5;

    typedef struct packed {
        logic [PL_W-1:0] payload_length;
        logic [TL_W-1:0] topic_length;
        logic [15:0]     packet_ident;
        logic [7:0]      conn_status;
        logic [2:0]      msg_kind;
        logic            done_res;
        logic [3:0]      byte_role;
        logic [7:0]      data_byte;
    } t_result;

endpackage

`default_nettype wire

// File: design/mqttpd_parse.sv
`default_nettype none

module mqttpd_parse import mqttpd_pkg::*; #(
    parameter int unsigned TOPIC_MAX   = TOPIC_MAX_DEF,
    parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF,
    parameter int unsigned MAX_FRAME   = MAX_FRAME_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    output t_result         o_res
);

    localparam int unsigned BC_W = $clog2(MAX_FRAME + 2);
    localparam int unsigned PC_W = $clog2(PAYLOAD_MAX + 1);

    logic [1:0]      r_phase, n_phase;
    logic [3:0]      r_ptype, n_ptype;
    logic [1:0]      r_qos, n_qos;
    logic [27:0]     r_rlen, n_rlen;
    logic [2:0]      r_lcnt, n_lcnt;
    logic [BC_W-1:0] r_bcnt, n_bcnt;
    logic [15:0]     r_tlen, n_tlen;
    logic [27:0]     r_sec, n_sec;
    logic [15:0]     r_id, n_id;
    logic [7:0]      r_code, n_code;
    logic [PC_W-1:0] r_pay, n_pay;
    logic            r_bad, n_bad;

    logic [27:0]     len_part;
    logic            kept_cur;
    logic            kept_new;
    logic            frame_ok;
    t_result         res;

    always_comb begin
        n_phase = r_phase;
        n_ptype = r_ptype;
        n_qos   = r_qos;
        n_rlen  = r_rlen;
        n_lcnt  = r_lcnt;
        n_tlen  = r_tlen;
        n_sec   = r_sec;
        n_id    = r_id;
        n_code  = r_code;
        n_pay   = r_pay;
        n_bad   = r_bad;
        n_bcnt  = (r_bcnt <= BC_W'(MAX_FRAME)) ? r_bcnt + 1'b1 : r_bcnt;
        res     = '0;
        res.data_byte = i_byte;
        res.byte_role = ROLE_IGNORED;
        res.done_res  = i_end;
        kept_cur = (r_tlen != 16'd0) && ({1'b0, r_tlen} < 17'(TOPIC_MAX));

        case (r_lcnt[1:0])
            2'd0:    len_part = {21'd0, i_byte[6:0]};
            2'd1:    len_part = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, i_byte[6:0], 14'd0};
            default: len_part = {i_byte[6:0], 21'd0};
        endcase

        case (r_phase)
            PH_TYPE: begin
                n_phase = PH_LEN;
                n_ptype = i_byte[7:4];
                n_qos   = i_byte[2:1];
                n_rlen  = '0;
                n_lcnt  = '0;
                n_bcnt  = BC_W'(1);
                n_tlen  = '0;
                n_sec   = '0;
                n_id    = '0;
                n_code  = '0;
                n_pay   = '0;
                n_bad   = 1'b0;
                res.byte_role = ROLE_TYPE;
            end
            PH_LEN: begin
                res.byte_role = ROLE_LEN;
                n_rlen = r_rlen + len_part;
                n_lcnt = r_lcnt + 3'd1;
                if (i_byte[7]) begin
                    if (n_lcnt >= 3'd4) begin
                        n_bad   = 1'b1;
                        n_phase = PH_TRAIL;
                    end
                end else begin
                    n_phase = (n_rlen == 28'd0) ? PH_TRAIL : PH_BODY;
                end
            end
            PH_BODY: begin
                res.byte_role = ROLE_VAR;
                case (r_ptype)
                    T_CONNACK: begin
                        if (r_sec == 28'd1) begin
                            n_code = i_byte;
                        end
                    end
                    T_PUBLISH: begin
                        if (r_sec == 28'd0) begin
                            n_tlen = {i_byte, 8'd0};
                            res.byte_role = ROLE_TOPIC_LEN;
                        end else if (r_sec == 28'd1) begin
                            n_tlen = r_tlen | {8'd0, i_byte};
                            res.byte_role = ROLE_TOPIC_LEN;
                        end else if (r_sec < 28'(r_tlen) + 28'd2) begin
                            res.byte_role = kept_cur ? ROLE_TOPIC_KEP : ROLE_TOPIC_DRP;
                        end else if (r_qos != 2'd0 && r_sec < 28'(r_tlen) + 28'd4) begin
                            n_id = {r_id[7:0], i_byte};
                            res.byte_role = ROLE_PKT_ID;
                        end else if (r_pay < PC_W'(PAYLOAD_MAX)) begin
                            n_pay = r_pay + 1'b1;
                            res.byte_role = ROLE_PAY_KEP;
                        end else begin
                            res.byte_role = ROLE_PAY_DRP;
                        end
                    end
                    T_SUBACK: begin
                        if (r_sec < 28'd2) begin
                            n_id = {r_id[7:0], i_byte};
                            res.byte_role = ROLE_PKT_ID;
                        end
                    end
                    T_PINGRESP, T_PUBACK: begin
                        res.byte_role = ROLE_VAR;
                    end
                    default: begin
                        res.byte_role = ROLE_IGNORED;
                    end
                endcase
                n_sec = r_sec + 28'd1;
                if (n_sec >= r_rlen) begin
                    n_phase = PH_TRAIL;
                end
            end
            default: begin
                res.byte_role = ROLE_IGNORED;
            end
        endcase

        kept_new = (n_tlen != 16'd0) && ({1'b0, n_tlen} < 17'(TOPIC_MAX));
        frame_ok = (n_phase == PH_TRAIL) && !n_bad && (n_bcnt <= BC_W'(MAX_FRAME));

        if (i_end) begin
            if (frame_ok) begin
                case (n_ptype)
                    T_CONNACK: begin
                        if (n_rlen >= 28'd2) begin
                            res.msg_kind    = KIND_CONNACK;
                            res.conn_status = n_code;
                        end
                    end
                    T_PUBLISH: begin
                        if (n_rlen >= 28'd2 && n_rlen >= 28'(n_tlen) + 28'd2 &&
                            (n_qos == 2'd0 || n_rlen >= 28'(n_tlen) + 28'd4)) begin
                            res.msg_kind       = KIND_PUBLISH;
                            res.topic_length   = kept_new ? TL_W'(n_tlen) : '0;
                            res.packet_ident   = (n_qos != 2'd0) ? n_id : 16'd0;
                            res.payload_length = PL_W'(n_pay);
                        end
                    end
                    T_SUBACK: begin
                        if (n_rlen >= 28'd3) begin
                            res.msg_kind     = KIND_SUBACK;
                            res.packet_ident = n_id;
                        end
                    end
                    T_PINGRESP: begin
                        res.msg_kind = KIND_PINGRESP;
                    end
                    T_PUBACK: begin
                        res.msg_kind = KIND_PUBACK;
                    end
                    default: begin
                        res.msg_kind = KIND_UNKNOWN;
                    end
                endcase
            end
            n_phase = PH_TYPE;
            n_ptype = '0;
            n_qos   = '0;
            n_rlen  = '0;
            n_lcnt  = '0;
            n_bcnt  = '0;
            n_tlen  = '0;
            n_sec   = '0;
            n_id    = '0;
            n_code  = '0;
            n_pay   = '0;
            n_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_ptype <= '0;
            r_qos   <= '0;
            r_rlen  <= '0;
            r_lcnt  <= '0;
            r_bcnt  <= '0;
            r_tlen  <= '0;
            r_sec   <= '0;
            r_id    <= '0;
            r_code  <= '0;
            r_pay   <= '0;
            r_bad   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_ptype <= n_ptype;
            r_qos   <= n_qos;
            r_rlen  <= n_rlen;
            r_lcnt  <= n_lcnt;
            r_bcnt  <= n_bcnt;
            r_tlen  <= n_tlen;
            r_sec   <= n_sec;
            r_id    <= n_id;
            r_code  <= n_code;
            r_pay   <= n_pay;
            r_bad   <= n_bad;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

// File: design/mqtt_packet_decoder_top.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: rx_byte; tlast: frame_end
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: data_byte, conn_status,
//                                              packet_ident, topic_length,
//                                              payload_length; tuser: byte_role,
//                                              msg_kind; tlast: done_res
//
// Every accepted byte produces exactly one result, which is registered before it is offered
// and is held back further only while the output side is stalled.
// The parser updates in the accepting cycle; one byte per cycle unless the output stalls.
// A two-entry output stage (result register plus skid register) decouples the sides;
// the input stalls only when both entries are full.
// Reset is synchronous and active low and clears the parser and both entries.
`default_nettype none

module mqtt_packet_decoder_top import mqttpd_pkg::*; #(
    parameter int unsigned TOPIC_MAX   = TOPIC_MAX_DEF,
    parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF,
    parameter int unsigned MAX_FRAME   = MAX_FRAME_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] data_byte, [15:8] conn_status,
                                             // [31:16] packet_ident, [37:32] topic_length,
                                             // [46:38] payload_length, [47] zero
    output logic [7:0]       m_axis_tuser,   // [3:0] byte_role, [6:4] msg_kind, [7] zero
    output logic             m_axis_tlast
);

    logic    in_xfer;
    t_result res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;

    assign s_axis_tready = !r_skid_vld;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    mqttpd_parse #(
        .TOPIC_MAX   (TOPIC_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .MAX_FRAME   (MAX_FRAME)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (m_axis_tready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (in_xfer) begin
                if (r_out_vld && !m_axis_tready) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (in_xfer) begin
            if (r_out_vld && !m_axis_tready) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out.done_res;
    assign m_axis_tdata  = {1'b0, r_out.payload_length, r_out.topic_length,
                            r_out.packet_ident, r_out.conn_status, r_out.data_byte};
    assign m_axis_tuser  = {1'b0, r_out.msg_kind, r_out.byte_role};

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held while output register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_vld && !m_axis_tready) |=> r_skid_vld)
        else $error("transfer during output stall not kept in skid register");

    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (m_axis_tuser[6:4] == KIND_UNKNOWN && m_axis_tdata[46:8] == 39'd0))
        else $error("summary fields set on a byte that does not end the frame");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
module tb import mqttpd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_BYTES   = 1800;

    typedef struct {
        logic [7:0] rx_byte;
        logic       frame_end;
        bit         pause;
    } t_rx_item;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [7:0] data_byte, [15:8] conn_status,
                                         // [31:16] packet_ident, [37:32] topic_length,
                                         // [46:38] payload_length, [47] zero
    logic [7:0]  m_axis_tuser;           // [3:0] byte_role, [6:4] msg_kind, [7] zero
    logic        m_axis_tlast;

    t_rx_item    rx_pending[$];
    t_result     results_due[$];
    logic [7:0]  frame_q[$];

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned bytes_built = 0;
    int unsigned send_gap    = 0;
    int unsigned send_calm   = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_calm  = 0;
    bit          byte_taken  = 1'b0;

    logic [1:0]  ps_phase;
    logic [3:0]  ps_type;
    logic [1:0]  ps_qos;
    int unsigned ps_rem_len;
    logic [2:0]  ps_len_bytes;
    logic [16:0] ps_frame_bytes;
    logic [15:0] ps_topic_len;
    int unsigned ps_offset;
    logic [15:0] ps_ident;
    logic [7:0]  ps_code;
    logic [8:0]  ps_payload;
    logic        ps_bad;

    mqtt_packet_decoder_top dut (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tlast,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .m_axis_tlast
    );

    function automatic void clear_parser();
        ps_phase       = PH_TYPE;
        ps_type        = 4'h0;
        ps_qos         = 2'd0;
        ps_rem_len     = 0;
        ps_len_bytes   = 3'd0;
        ps_frame_bytes = 17'd0;
        ps_topic_len   = 16'h0;
        ps_offset      = 0;
        ps_ident       = 16'h0;
        ps_code        = 8'h00;
        ps_payload     = 9'd0;
        ps_bad         = 1'b0;
    endfunction

    function automatic bit topic_fits();
        return ps_topic_len > 0 && ps_topic_len < TOPIC_MAX_DEF;
    endfunction

    function automatic t_result decode_rx_byte(logic [7:0] b, logic fin);
        t_result     res;
        int unsigned r;
        int unsigned t;
        res = '0;
        res.data_byte = b;
        res.done_res  = fin;
        res.byte_role = ROLE_IGNORED;
        if (ps_frame_bytes <= MAX_FRAME_DEF) ps_frame_bytes++;
        case (ps_phase)
            PH_TYPE: begin
                clear_parser();
                ps_frame_bytes = 17'd1;
                ps_type        = b[7:4];
                ps_qos         = b[2:1];
                ps_phase       = PH_LEN;
                res.byte_role  = ROLE_TYPE;
            end
            PH_LEN: begin
                res.byte_role = ROLE_LEN;
                ps_rem_len    = ps_rem_len + (32'(b[6:0]) << (7 * ps_len_bytes[1:0]));
                ps_len_bytes++;
                if (b[7]) begin
                    if (ps_len_bytes >= 4) begin
                        ps_bad   = 1'b1;
                        ps_phase = PH_TRAIL;
                    end
                end else begin
                    ps_phase = (ps_rem_len == 0) ? PH_TRAIL : PH_BODY;
                end
            end
            PH_BODY: begin
                t = ps_topic_len;
                res.byte_role = ROLE_VAR;
                case (ps_type)
                    T_CONNACK: begin
                        if (ps_offset == 1) ps_code = b;
                    end
                    T_PUBLISH: begin
                        if (ps_offset == 0) begin
                            ps_topic_len  = {b, 8'h00};
                            res.byte_role = ROLE_TOPIC_LEN;
                        end else if (ps_offset == 1) begin
                            ps_topic_len  = ps_topic_len | {8'h00, b};
                            res.byte_role = ROLE_TOPIC_LEN;
                        end else if (ps_offset < 2 + t) begin
                            res.byte_role = topic_fits() ? ROLE_TOPIC_KEP : ROLE_TOPIC_DRP;
                        end else if (ps_qos != 0 && ps_offset < 4 + t) begin
                            ps_ident      = {ps_ident[7:0], b};
                            res.byte_role = ROLE_PKT_ID;
                        end else if (ps_payload < PAYLOAD_MAX_DEF) begin
                            ps_payload++;
                            res.byte_role = ROLE_PAY_KEP;
                        end else begin
                            res.byte_role = ROLE_PAY_DRP;
                        end
                    end
                    T_SUBACK: begin
                        if (ps_offset < 2) begin
                            ps_ident      = {ps_ident[7:0], b};
                            res.byte_role = ROLE_PKT_ID;
                        end
                    end
                    T_PINGRESP, T_PUBACK: ;
                    default: res.byte_role = ROLE_IGNORED;
                endcase
                ps_offset++;
                if (ps_offset >= ps_rem_len) ps_phase = PH_TRAIL;
            end
            default: ;
        endcase

        if (fin) begin
            r = ps_rem_len;
            t = ps_topic_len;
            if (ps_phase == PH_TRAIL && !ps_bad && ps_frame_bytes <= MAX_FRAME_DEF) begin
                case (ps_type)
                    T_CONNACK: begin
                        if (r >= 2) begin
                            res.msg_kind    = KIND_CONNACK;
                            res.conn_status = ps_code;
                        end
                    end
                    T_PUBLISH: begin
                        if (r >= 2 + t && (ps_qos == 0 || r >= 4 + t)) begin
                            res.msg_kind       = KIND_PUBLISH;
                            res.topic_length   = topic_fits() ? ps_topic_len[TL_W-1:0] : '0;
                            res.packet_ident   = (ps_qos != 0) ? ps_ident : 16'h0;
                            res.payload_length = ps_payload;
                        end
                    end
                    T_SUBACK: begin
                        if (r >= 3) begin
                            res.msg_kind     = KIND_SUBACK;
                            res.packet_ident = ps_ident;
                        end
                    end
                    T_PINGRESP: res.msg_kind = KIND_PINGRESP;
                    T_PUBACK:   res.msg_kind = KIND_PUBACK;
                    default: ;
                endcase
            end
            clear_parser();
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm = $urandom_range(20, 300);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 985) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            flag_mismatch("unexpected result transfer, data_byte", m_axis_tdata[7:0], 0);
            return;
        end
        want = results_due.pop_front();
        if (m_axis_tdata[7:0] !== want.data_byte)
            flag_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
        if (m_axis_tuser[3:0] !== want.byte_role)
            flag_mismatch("byte_role", m_axis_tuser[3:0], want.byte_role);
        if (m_axis_tlast !== want.done_res)
            flag_mismatch("done_res", m_axis_tlast, want.done_res);
        if (m_axis_tuser[6:4] !== want.msg_kind)
            flag_mismatch("msg_kind", m_axis_tuser[6:4], want.msg_kind);
        if (m_axis_tdata[15:8] !== want.conn_status)
            flag_mismatch("conn_status", m_axis_tdata[15:8], want.conn_status);
        if (m_axis_tdata[31:16] !== want.packet_ident)
            flag_mismatch("packet_ident", m_axis_tdata[31:16], want.packet_ident);
        if (m_axis_tdata[37:32] !== want.topic_length)
            flag_mismatch("topic_length", m_axis_tdata[37:32], want.topic_length);
        if (m_axis_tdata[46:38] !== want.payload_length)
            flag_mismatch("payload_length", m_axis_tdata[46:38], want.payload_length);
        if (m_axis_tdata[47] !== 1'b0 || m_axis_tuser[7] !== 1'b0)
            flag_mismatch("padding bits", {m_axis_tdata[47], m_axis_tuser[7]}, 0);
    endtask

    task automatic start_frame(logic [7:0] hdr, int unsigned rem, bit pad);
        int unsigned v;
        v = rem;
        frame_q.delete();
        frame_q.push_back(hdr);
        do begin
            frame_q.push_back({(v > 127) ? 1'b1 : 1'b0, 7'(v)});
            v = v >> 7;
        end while (v != 0);
        if (pad && frame_q.size() < 5) begin
            frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] | 8'h80;
            frame_q.push_back(8'h00);
        end
    endtask

    task automatic add_random(int unsigned n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic commit_frame(int unsigned trail, int unsigned cut, bit pause);
        t_rx_item it;
        add_random(trail);
        while (cut > 0 && frame_q.size() > 1) begin
            void'(frame_q.pop_back());
            cut--;
        end
        bytes_built += (frame_q.size() > trail) ? frame_q.size() - trail : 1;
        foreach (frame_q[i]) begin
            it.rx_byte   = frame_q[i];
            it.frame_end = (i == frame_q.size() - 1);
            it.pause     = pause && (i == 0);
            rx_pending.push_back(it);
        end
        frame_q.delete();
    endtask

    task automatic queue_fixed(logic [7:0] bytes_in[$]);
        frame_q = bytes_in;
        commit_frame(0, 0, 1'b0);
    endtask

    task automatic queue_simple(logic [3:0] kind_type, int unsigned usual_rem, bit pad);
        int unsigned rem;
        rem = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : usual_rem;
        start_frame({kind_type, 4'($urandom)}, rem, pad);
        add_random(rem);
    endtask

    task automatic queue_publish(bit pad);
        int unsigned qos;
        int unsigned tl;
        int unsigned pl;
        int unsigned rem;
        int unsigned body_len;
        int unsigned r;
        qos = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 70)      tl = $urandom_range(0, 8);
        else if (r < 88) tl = $urandom_range(60, 66);
        else if (r < 95) tl = $urandom_range(9, 130);
        else             tl = $urandom_range(0, 65535);
        r = $urandom_range(0, 99);
        if (r < 80)      pl = $urandom_range(0, 12);
        else if (r < 95) pl = $urandom_range(13, 40);
        else             pl = $urandom_range(250, 262);
        if (tl > 130) begin
            // Huge declared topic in a short frame.
            body_len = $urandom_range(2, 24);
            rem = body_len;
        end else begin
            body_len = 2 + tl + ((qos != 0) ? 2 : 0) + pl;
            rem = body_len;
            if ($urandom_range(0, 9) == 0) rem = $urandom_range(0, body_len + 3);
        end
        start_frame({T_PUBLISH, 1'($urandom), 2'(qos), 1'($urandom)}, rem, pad);
        frame_q.push_back(8'(tl >> 8));
        frame_q.push_back(8'(tl));
        add_random(body_len - 2);
    endtask

    task automatic queue_random_frame(bit force_pause);
        int unsigned sel;
        int unsigned trail;
        int unsigned cut;
        bit          pad;
        logic [3:0]  odd_type;
        sel   = $urandom_range(0, 99);
        trail = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
        cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0;
        pad   = ($urandom_range(0, 7) == 0);
        if (sel < 40) begin
            queue_publish(pad);
        end else if (sel < 52) begin
            queue_simple(T_CONNACK, 2, pad);
        end else if (sel < 64) begin
            queue_simple(T_SUBACK, $urandom_range(3, 6), pad);
        end else if (sel < 72) begin
            queue_simple(T_PUBACK, 2, pad);
        end else if (sel < 80) begin
            queue_simple(T_PINGRESP, 0, pad);
        end else if (sel < 88) begin
            do odd_type = 4'($urandom);
            while (odd_type == T_CONNACK || odd_type == T_PUBLISH || odd_type == T_PUBACK ||
                   odd_type == T_SUBACK || odd_type == T_PINGRESP);
            queue_simple(odd_type, $urandom_range(0, 6), pad);
        end else if (sel < 93) begin
            // Length field that never terminates within four bytes.
            frame_q.delete();
            frame_q.push_back(8'($urandom));
            repeat (4) frame_q.push_back(8'($urandom) | 8'h80);
            add_random($urandom_range(1, 3));
        end else begin
            frame_q.delete();
            add_random($urandom_range(1, 6));
        end
        commit_frame(trail, cut, force_pause || ($urandom_range(0, 39) == 0));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            byte_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() > 0 &&
                         !(rx_pending[0].pause && results_due.size() != 0)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_pending[0].rx_byte;
                s_axis_tlast  <= rx_pending[0].frame_end;
                send_gap = next_gap(send_calm);
                void'(rx_pending.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = next_gap(stall_calm);
        end
    end

    // Results are checked before this edge's input transfer is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(decode_rx_byte(s_axis_tdata, s_axis_tlast));
                byte_taken = 1'b1;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial begin
        clear_parser();

        queue_fixed('{8'hD0});
        queue_fixed('{8'hD0, 8'h00});
        queue_fixed('{8'h40, 8'h00});
        queue_fixed('{8'h20, 8'h02, 8'h00, 8'hFF});
        queue_fixed('{8'h90, 8'h03, 8'hFF, 8'hFF, 8'h80});
        queue_fixed('{8'h30, 8'h04, 8'h00, 8'h01, 8'h61, 8'h62});
        queue_fixed('{8'h3F, 8'h06, 8'h00, 8'h00, 8'hAB, 8'hCD, 8'hEE, 8'hFF});
        queue_fixed('{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
        queue_fixed('{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'h7F});

        bytes_built = 0;
        queue_random_frame(1'b1);
        while (bytes_built < RANDOM_BYTES) queue_random_frame(1'b0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
design/mqttpd_pkg.sv
design/mqttpd_parse.sv
design/mqtt_packet_decoder_top.sv
sim/tb.sv
